[hw/rtl/sdp2_pkg.sv]
// shared constants and types for the binary64 power-of-two scaler
`timescale 1ns / 1ps
`default_nettype none
package sdp2_pkg;
    localparam int unsigned ExpW  = 11;
    localparam int unsigned FracW = 52;
    localparam int unsigned SigW  = 53;
    // wide signed exponent, never wraps for any 32-bit power
    localparam int unsigned WexpW = 35;
    localparam logic [ExpW-1:0] ExpMax = 11'h7ff;

    // operand class decoded in the first stage
    typedef enum logic [1:0] {
        CLS_NORM = 2'd0,
        CLS_ZERO = 2'd1,
        CLS_PASS = 2'd2
    } cls_t;
endpackage
`default_nettype wire

[hw/rtl/scale_double_by_power_of_two_top.sv]
// ldexp for binary64 operands as a four-stage pipeline
// throughput: one request per cycle while the output is not stalled; the stages
//   advance together and all hold while a valid result waits with out_ready low
// reset: rst_n clears all valid bits; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module scale_double_by_power_of_two_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] value_bits,
    input  wire logic signed [31:0] scale_power,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      result_bits
);
    localparam int unsigned SW = sdp2_pkg::SigW;
    localparam int unsigned EW = sdp2_pkg::WexpW;

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: classify and count leading zeros of the fraction
    sdp2_pkg::cls_t c1_reg;
    logic [63:0]    b1_reg;
    logic [31:0]    p1_reg;
    logic [5:0]     lz1_reg;
    // stage 2: normalized significand and scaled exponent
    sdp2_pkg::cls_t c2_reg;
    logic [63:0]    b2_reg;
    logic [SW-1:0]  m2_reg;
    logic signed [EW-1:0] e2_reg;
    // stage 3: range decision and right shift
    logic [63:0]    r3_reg;
    logic           fin3_reg;
    logic           s3_reg;
    logic [SW-1:0]  q3_reg;
    logic           rnd3_reg;
    logic           stk3_reg;
    // stage 4: output
    logic [63:0]    r4_reg;

    assign adv       = !v4_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = v4_reg;
    assign result_bits = r4_reg;

    // leading zero count of the 52-bit fraction, with the hidden bit above it
    logic [5:0] lz_next;
    always_comb
    begin
        lz_next = 6'd52;
        for (int i = 0; i < 52; i++)
        begin
            if (value_bits[i])
            begin
                lz_next = 6'(51 - i);
            end
        end
    end

    sdp2_pkg::cls_t c1_next;
    always_comb
    begin
        if (value_bits[62:0] == 63'd0)
        begin
            c1_next = sdp2_pkg::CLS_ZERO;
        end
        else if (value_bits[62:52] == sdp2_pkg::ExpMax)
        begin
            c1_next = sdp2_pkg::CLS_PASS;
        end
        else
        begin
            c1_next = sdp2_pkg::CLS_NORM;
        end
    end

    // normalize subnormals and add the power
    logic [SW-1:0]        m2_next;
    logic signed [EW-1:0] e2_next;
    always_comb
    begin
        if (b1_reg[62:52] == 11'd0)
        begin
            // subnormal: shift so the top set bit lands at bit 52
            m2_next = {1'b0, b1_reg[51:0]} << (lz1_reg + 6'd1);
            e2_next = -EW'(signed'({1'b0, lz1_reg}));
        end
        else
        begin
            m2_next = {1'b1, b1_reg[51:0]};
            e2_next = EW'(signed'({1'b0, b1_reg[62:52]}));
        end
        e2_next = e2_next + EW'(signed'(p1_reg));
    end

    // range decision and underflow shift
    logic [63:0]   r3_next;
    logic          fin3_next;
    logic [SW-1:0] q3_next;
    logic          rnd3_next;
    logic          stk3_next;
    logic signed [EW-1:0] sh_w;
    logic [5:0]    sh;
    logic [2*SW-1:0] ext;
    always_comb
    begin
        r3_next   = b2_reg;
        fin3_next = 1'b1;
        q3_next   = '0;
        rnd3_next = 1'b0;
        stk3_next = 1'b0;
        sh_w      = EW'(1) - e2_reg;
        sh        = sh_w[5:0];
        ext       = '0;
        unique case (c2_reg)
            sdp2_pkg::CLS_ZERO:
            begin
                r3_next = '0;
            end
            sdp2_pkg::CLS_PASS:
            begin
                r3_next = b2_reg;
            end
            default:
            begin
                if (e2_reg >= EW'(signed'({1'b0, sdp2_pkg::ExpMax})))
                begin
                    r3_next = {b2_reg[63], sdp2_pkg::ExpMax, 52'd0};
                end
                else if (e2_reg >= EW'(1))
                begin
                    r3_next = {b2_reg[63], e2_reg[10:0], m2_reg[51:0]};
                end
                else if (sh_w >= EW'(54))
                begin
                    r3_next = {b2_reg[63], 63'd0};
                end
                else
                begin
                    // shift by 1..53, keep the dropped bits below
                    fin3_next = 1'b0;
                    ext       = {m2_reg, {SW{1'b0}}} >> sh;
                    q3_next   = ext[2*SW-1:SW];
                    rnd3_next = ext[SW-1];
                    stk3_next = |ext[SW-2:0];
                end
            end
        endcase
    end

    // round to nearest even
    logic [63:0]   r4_next;
    logic [SW-1:0] qr;
    always_comb
    begin
        qr = q3_reg + SW'(rnd3_reg && (stk3_reg || q3_reg[0]));
        if (fin3_reg)
        begin
            r4_next = r3_reg;
        end
        else
        begin
            r4_next = {s3_reg, 10'd0, qr};
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg   <= c1_next;
            b1_reg   <= value_bits;
            p1_reg   <= scale_power;
            lz1_reg  <= lz_next;
            c2_reg   <= c1_reg;
            b2_reg   <= b1_reg;
            m2_reg   <= m2_next;
            e2_reg   <= e2_next;
            r3_reg   <= r3_next;
            fin3_reg <= fin3_next;
            s3_reg   <= b2_reg[63];
            q3_reg   <= q3_next;
            rnd3_reg <= rnd3_next;
            stk3_reg <= stk3_next;
            r4_reg   <= r4_next;
        end
    end
endmodule
`default_nettype wire

[tb/scale_double_by_power_of_two_checker.sv]
// checker for the binary64 power-of-two scaler: predicts and compares results
`timescale 1ns / 1ps
module scale_double_by_power_of_two_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [63:0] value_bits,
    input  wire logic signed [31:0] scale_power,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [63:0] result_bits,
    output int               fail_count,
    output int               pending_count
);
    logic [63:0] scaled_q[$];

    // ldexp with round to nearest even on underflow
    function automatic logic [63:0] ldexp_bits(input logic [63:0] bits,
                                               input logic signed [31:0] pw);
        logic        sgn;
        longint      ex;
        logic [52:0] sig;
        longint      sh;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] wide;
        sgn = bits[63];
        ex  = longint'(bits[62:52]);
        sig = {1'b0, bits[51:0]};
        if (bits[62:0] == 63'd0)
            return 64'd0;
        if (bits[62:52] == sdp2_pkg::ExpMax)
            return bits;
        // normalize subnormal operands
        if (ex == 0)
        begin
            ex = 1;
            while (!sig[52])
            begin
                sig = sig << 1;
                ex  = ex - 1;
            end
        end
        else
            sig[52] = 1'b1;
        ex = ex + longint'(pw);
        if (ex >= 2047)
            return {sgn, sdp2_pkg::ExpMax, 52'd0};
        if (ex >= 1)
            return {sgn, ex[10:0], sig[51:0]};
        sh = 1 - ex;
        if (sh >= 54)
            return {sgn, 63'd0};
        wide = {11'd0, sig};
        q    = wide >> sh;
        rem  = wide & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        return {sgn, 63'd0} | q;
    endfunction

    // mismatch report
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
    end

    assign pending_count = scaled_q.size();

    // track requests and check results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                scaled_q.push_back(ldexp_bits(value_bits, scale_power));
            if (out_valid && out_ready)
            begin
                if (scaled_q.size() == 0)
                    report_mismatch("unexpected result", result_bits, 64'd0);
                else if (result_bits !== scaled_q[0])
                    report_mismatch("result_bits", result_bits, scaled_q.pop_front());
                else
                    void'(scaled_q.pop_front());
            end
        end
    end
endmodule

[tb/scale_double_by_power_of_two_top_tb.sv]
// stimulus and verdict for the binary64 power-of-two scaler
`timescale 1ns / 1ps
module scale_double_by_power_of_two_top_tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] value_bits = 64'd0;
    logic signed [31:0] scale_power = 32'sd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] result_bits;
    int          fail_count;
    int          pending_count;
    bit          steady = 1'b0;

    always #6 clk = ~clk;

    scale_double_by_power_of_two_top u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .value_bits(value_bits), .scale_power(scale_power),
        .out_valid(out_valid), .out_ready(out_ready), .result_bits(result_bits)
    );

    scale_double_by_power_of_two_checker u_chk (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .value_bits(value_bits), .scale_power(scale_power),
        .out_valid(out_valid), .out_ready(out_ready), .result_bits(result_bits),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // receiver stalls
    always @(negedge clk)
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 21);

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random operand biased toward special classes
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        v = rand64();
        case ($urandom_range(9))
            0: v[62:52] = 11'h000;
            1: v[62:52] = 11'h7ff;
            2: v[62:0]  = 63'd0;
            3: v[62:52] = 11'h000 + 11'($urandom_range(60));
            4: v[62:52] = 11'h7ff - 11'($urandom_range(60));
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_power();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'(int'($urandom_range(2200)) - 1100);
            2: return 32'(int'($urandom_range(120)) - 60);
            3: return 32'(-int'($urandom_range(1130)) + 1020 - 1020);
            default: return 32'(int'($urandom_range(2100)) - 2100 + $urandom_range(2100));
        endcase
    endfunction

    // drive one request and wait for acceptance; valid drops only while idling
    task automatic send_request(input logic [63:0] v, input logic [31:0] p);
        while (!steady && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        value_bits  <= v;
        scale_power <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed extremes
        send_request(64'h0000000000000000, 32'sd5);
        send_request(64'h8000000000000000, -32'sd5);
        send_request(64'h7ff0000000000000, 32'sd1);
        send_request(64'hfff0000000000000, -32'sd1);
        send_request(64'h7ff8000000000001, 32'sd3);
        send_request(64'h7ff0000000000001, 32'sd0);
        send_request(64'h0000000000000001, 32'sd0);
        send_request(64'h0000000000000001, 32'sd1074);
        send_request(64'h800fffffffffffff, 32'sd1);
        send_request(64'h3ff0000000000000, 32'sd1023);
        send_request(64'h3ff0000000000000, 32'sd1024);
        send_request(64'h7fefffffffffffff, 32'sd1);
        send_request(64'h3ff0000000000000, -32'sd1074);
        send_request(64'h3ff0000000000000, -32'sd1075);
        send_request(64'h3ff8000000000000, -32'sd1075);
        send_request(64'h0010000000000000, -32'sd1);
        send_request(64'h001fffffffffffff, -32'sd1);
        send_request(64'h000fffffffffffff, 32'sd1);
        send_request(64'hffffffffffffffff, 32'h7fffffff);
        send_request(64'h3ff0000000000000, 32'h7fffffff);
        send_request(64'hbff0000000000000, 32'h80000000);
        send_request(64'h0000000000000003, -32'sd1);
        send_request(64'h0000000000000001, 32'h80000000);
        in_valid <= 1'b0;
        // drain before random traffic
        while (pending_count != 0)
            @(negedge clk);
        for (int i = 0; i < 1750; i++)
        begin
            steady = (i >= 600 && i < 800);
            send_request(pick_value(), pick_power());
        end
        in_valid <= 1'b0;
        steady = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

[scale_double_by_power_of_two_top.f]
hw/rtl/sdp2_pkg.sv
hw/rtl/scale_double_by_power_of_two_top.sv
tb/scale_double_by_power_of_two_checker.sv
tb/scale_double_by_power_of_two_top_tb.sv
